>>> hdl/hnrp_pkg.sv
// Shared types and constants of the H.264 NAL to RTP packetizer.
`default_nettype none

package hnrp_pkg;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_TIMESTAMP_STEP = 2'd0;
    localparam logic [1:0] REG_PAYLOAD_LIMIT  = 2'd1;
    localparam logic [1:0] REG_RTP_PT         = 2'd2;
    localparam logic [1:0] REG_STREAM_SSRC    = 2'd3;

    // Register values after reset
    localparam logic [16:0] TIMESTAMP_STEP_RESET = 17'd3600;
    localparam logic [10:0] PAYLOAD_LIMIT_RESET  = 11'd1400;
    localparam logic [6:0]  RTP_PT_RESET         = 7'd96;
    localparam logic [31:0] STREAM_SSRC_RESET    = 32'd10;

    // Protocol constants
    localparam logic [7:0]  RTP_VERSION_BYTE = 8'h80;
    localparam logic [4:0]  FU_A_TYPE        = 5'd28;
    localparam logic [10:0] MIN_PAYLOAD      = 11'd2;

    typedef struct packed {
        logic [7:0]  nal_byte;
        logic [15:0] nal_length;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       packet_end;
        logic       nal_end;
    } out_item_t;

    typedef struct packed {
        logic [16:0] timestamp_step;
        logic [10:0] payload_limit;
        logic [6:0]  rtp_pt;
        logic [31:0] stream_ssrc;
    } cfg_t;

    // One classified input byte: what the back end has to emit for it
    typedef struct packed {
        logic        hdr;       // emit a 12-byte RTP header
        logic        marker;
        logic [15:0] seq;
        logic [31:0] ts;
        logic        fu;        // emit FU indicator and FU header
        logic [7:0]  fu_ind;
        logic [7:0]  fu_hdr;
        logic        has_data;  // emit the NAL byte itself
        logic [7:0]  data;
        logic        pe;        // flags for the final byte of the transaction
        logic        ne;
    } job_t;

endpackage

`default_nettype wire

>>> hdl/hnrp_fifo.sv
// Small register queue used for the job queue and the output byte queue.
`default_nettype none

module hnrp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic      [WIDTH-1:0] rd_data,
    output logic                  empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        unique case ({do_wr, do_rd})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

>>> hdl/hnrp_front.sv
// Front end: tracks NAL position and fragment state, turns each byte into a job.
`default_nettype none

module hnrp_front #(
    parameter int LENGTH_BITS = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire hnrp_pkg::in_item_t in_item,
    input  wire hnrp_pkg::cfg_t     cfg,
    output hnrp_pkg::job_t          job
);
    import hnrp_pkg::*;

    localparam int CW = (LENGTH_BITS >= 16) ? LENGTH_BITS + 1 : 17;

    logic [15:0]          seq_reg, seq_next;
    logic [31:0]          ts_reg, ts_next;
    logic [LENGTH_BITS-1:0] pos_reg, pos_next;
    logic [10:0]          fill_reg, fill_next;
    logic [7:0]           nal_hdr_reg, nal_hdr_next;
    logic                 frag_reg, frag_next;

    logic [10:0]   lim;
    logic [CW-1:0] len_x, pos_x, lim_x, remaining;
    logic          last, end_frag, fill_end, frag_pick;
    logic [11:0]   fill_inc;
    logic [15:0]   seq_inc;
    logic [7:0]    b;

    always_comb
    begin
        b         = in_item.nal_byte;
        lim       = (cfg.payload_limit < MIN_PAYLOAD) ? MIN_PAYLOAD : cfg.payload_limit;
        len_x     = CW'(in_item.nal_length);
        pos_x     = CW'(pos_reg);
        lim_x     = CW'(lim);
        last      = (pos_x + CW'(1)) >= len_x;
        remaining = (len_x > pos_x) ? len_x - pos_x : CW'(1);
        end_frag  = remaining <= lim_x;
        fill_inc  = {1'b0, fill_reg} + 12'd1;
        fill_end  = last || (fill_inc >= {1'b0, lim});
        seq_inc   = seq_reg + 16'd1;
        frag_pick = len_x > lim_x;

        job          = '0;
        seq_next     = seq_reg;
        ts_next      = ts_reg;
        pos_next     = pos_reg;
        fill_next    = fill_reg;
        nal_hdr_next = nal_hdr_reg;
        frag_next    = frag_reg;

        if (accept)
        begin
            if (pos_reg == '0)
            begin
                // First byte: open a NAL and pick its packet mode
                ts_next      = ts_reg + {15'd0, cfg.timestamp_step};
                nal_hdr_next = b;
                frag_next    = frag_pick;
                seq_next     = seq_inc;
                job.hdr      = 1'b1;
                job.seq      = seq_inc;
                job.ts       = ts_next;
                job.pe       = last;
                job.ne       = last;
                if (!frag_pick)
                begin
                    fill_next    = '0;
                    job.has_data = 1'b1;
                    job.data     = b;
                end
                else
                begin
                    // NAL header byte is replaced by the FU prefix
                    fill_next  = 11'd1;
                    job.fu     = 1'b1;
                    job.fu_ind = {b[7:5], FU_A_TYPE};
                    job.fu_hdr = {1'b1, 1'b0, 1'b0, b[4:0]};
                end
            end
            else if (!frag_reg)
            begin
                job.has_data = 1'b1;
                job.data     = b;
                job.pe       = last;
                job.ne       = last;
            end
            else
            begin
                if (fill_reg == '0)
                begin
                    // Open a new fragment; E decided from bytes still to come
                    seq_next   = seq_inc;
                    job.hdr    = 1'b1;
                    job.marker = end_frag;
                    job.seq    = seq_inc;
                    job.ts     = ts_reg;
                    job.fu     = 1'b1;
                    job.fu_ind = {nal_hdr_reg[7:5], FU_A_TYPE};
                    job.fu_hdr = {1'b0, end_frag, 1'b0, nal_hdr_reg[4:0]};
                end
                fill_next    = fill_end ? '0 : fill_inc[10:0];
                job.has_data = 1'b1;
                job.data     = b;
                job.pe       = fill_end;
                job.ne       = last;
            end

            if (last)
            begin
                pos_next  = '0;
                fill_next = '0;
            end
            else
            begin
                pos_next = pos_reg + LENGTH_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg     <= '0;
            ts_reg      <= '0;
            pos_reg     <= '0;
            fill_reg    <= '0;
            nal_hdr_reg <= '0;
            frag_reg    <= 1'b0;
        end
        else
        begin
            seq_reg     <= seq_next;
            ts_reg      <= ts_next;
            pos_reg     <= pos_next;
            fill_reg    <= fill_next;
            nal_hdr_reg <= nal_hdr_next;
            frag_reg    <= frag_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/hnrp_back.sv
// Back end: serializes one job into header, FU prefix and data bytes.
`default_nettype none

module hnrp_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire hnrp_pkg::job_t job,
    input  wire logic           job_empty,
    output logic                job_pop,
    input  wire hnrp_pkg::cfg_t cfg,
    input  wire logic           out_full,
    output logic                out_wr,
    output hnrp_pkg::out_item_t out_item
);
    import hnrp_pkg::*;

    localparam logic [3:0] SLOT_VERSION = 4'd0;
    localparam logic [3:0] SLOT_PTYPE   = 4'd1;
    localparam logic [3:0] SLOT_SEQ_HI  = 4'd2;
    localparam logic [3:0] SLOT_SEQ_LO  = 4'd3;
    localparam logic [3:0] SLOT_TS_3    = 4'd4;
    localparam logic [3:0] SLOT_TS_2    = 4'd5;
    localparam logic [3:0] SLOT_TS_1    = 4'd6;
    localparam logic [3:0] SLOT_TS_0    = 4'd7;
    localparam logic [3:0] SLOT_SSRC_3  = 4'd8;
    localparam logic [3:0] SLOT_SSRC_2  = 4'd9;
    localparam logic [3:0] SLOT_SSRC_1  = 4'd10;
    localparam logic [3:0] SLOT_SSRC_0  = 4'd11;
    localparam logic [3:0] SLOT_FU_IND  = 4'd12;
    localparam logic [3:0] SLOT_FU_HDR  = 4'd13;
    localparam logic [3:0] SLOT_DATA    = 4'd14;

    logic [3:0] slot_reg, slot_next;
    logic       started_reg, started_next;
    logic [3:0] slot, slot_after;
    logic       final_byte;

    always_comb
    begin
        slot = started_reg ? slot_reg : (job.hdr ? SLOT_VERSION : SLOT_DATA);

        final_byte = (slot == SLOT_DATA)
                  || ((slot == SLOT_FU_HDR) && !job.has_data)
                  || ((slot == SLOT_SSRC_0) && !job.fu && !job.has_data);

        if (slot == SLOT_SSRC_0)
        begin
            slot_after = job.fu ? SLOT_FU_IND : SLOT_DATA;
        end
        else
        begin
            slot_after = slot + 4'd1;
        end

        out_wr  = !job_empty && !out_full;
        job_pop = out_wr && final_byte;

        out_item.packet_end = final_byte ? job.pe : 1'b0;
        out_item.nal_end    = final_byte ? job.ne : 1'b0;
        unique case (slot)
            SLOT_VERSION: out_item.out_byte = RTP_VERSION_BYTE;
            SLOT_PTYPE:   out_item.out_byte = {job.marker, cfg.rtp_pt};
            SLOT_SEQ_HI:  out_item.out_byte = job.seq[15:8];
            SLOT_SEQ_LO:  out_item.out_byte = job.seq[7:0];
            SLOT_TS_3:    out_item.out_byte = job.ts[31:24];
            SLOT_TS_2:    out_item.out_byte = job.ts[23:16];
            SLOT_TS_1:    out_item.out_byte = job.ts[15:8];
            SLOT_TS_0:    out_item.out_byte = job.ts[7:0];
            SLOT_SSRC_3:  out_item.out_byte = cfg.stream_ssrc[31:24];
            SLOT_SSRC_2:  out_item.out_byte = cfg.stream_ssrc[23:16];
            SLOT_SSRC_1:  out_item.out_byte = cfg.stream_ssrc[15:8];
            SLOT_SSRC_0:  out_item.out_byte = cfg.stream_ssrc[7:0];
            SLOT_FU_IND:  out_item.out_byte = job.fu_ind;
            SLOT_FU_HDR:  out_item.out_byte = job.fu_hdr;
            SLOT_DATA:    out_item.out_byte = job.data;
            default:      out_item.out_byte = '0;
        endcase

        slot_next    = slot_reg;
        started_next = started_reg;
        if (out_wr)
        begin
            if (final_byte)
            begin
                started_next = 1'b0;
            end
            else
            begin
                started_next = 1'b1;
                slot_next    = slot_after;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg    <= SLOT_VERSION;
            started_reg <= 1'b0;
        end
        else
        begin
            slot_reg    <= slot_next;
            started_reg <= started_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/h264_nal_rtp_packetizer.sv
// Top level of the H.264 NAL unit to RTP packetizer (single-NAL and FU-A).
//
// Push NAL bytes one per transaction, header byte first, each with the total
// NAL length; pop the RTP packet stream one byte per transaction, with
// packet_end on the last byte of each packet and nal_end on the last byte of
// each NAL. Every packet opens with a 12-byte RTP header; FU-A fragments add
// the FU indicator and FU header. A front end classifies each input byte in
// the cycle it is accepted and queues a job (up to JOB_DEPTH deep); a back
// end serializes the head job into the output queue (OUT_DEPTH bytes) at one
// byte per cycle while a job waits and the output queue has room. Input is
// taken every cycle while the job queue has room. The sustained rate is set
// by the back end's serializer: each packet opening adds 12 header bytes (14
// for an FU-A fragment) to the payload bytes, and a NAL of L bytes split at
// limit P is sent as ceil(L / P) packets. The first output byte of an item
// passes the job queue and then the output queue before it shows on the
// result ports. Configuration writes are always taken (ready is held high);
// write them only while no bytes are in flight. A payload limit below 2 acts
// as 2.
`default_nettype none

module h264_nal_rtp_packetizer #(
    parameter int LENGTH_BITS = 16,
    parameter int JOB_DEPTH   = 4,
    parameter int OUT_DEPTH   = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // input queue side
    input  wire logic               push,
    output logic                    full,
    input  wire hnrp_pkg::in_item_t  in_item,
    // result queue side
    output logic                    empty,
    input  wire logic               pop,
    output hnrp_pkg::out_item_t      out_item,
    // configuration write channel
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [31:0]        cfg_data
);
    import hnrp_pkg::*;

    cfg_t      cfg_reg, cfg_next;
    job_t      job_in, job_head;
    out_item_t byte_item;
    logic      accept, job_full, job_empty, job_pop, out_wr, out_full;
    logic [$bits(job_t)-1:0]      job_rd_bits;
    logic [$bits(out_item_t)-1:0] out_rd_bits;

    // Configuration registers: take every write at once
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_TIMESTAMP_STEP: cfg_next.timestamp_step = cfg_data[16:0];
                REG_PAYLOAD_LIMIT:  cfg_next.payload_limit  = cfg_data[10:0];
                REG_RTP_PT:         cfg_next.rtp_pt         = cfg_data[6:0];
                REG_STREAM_SSRC:    cfg_next.stream_ssrc    = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timestamp_step <= TIMESTAMP_STEP_RESET;
            cfg_reg.payload_limit  <= PAYLOAD_LIMIT_RESET;
            cfg_reg.rtp_pt         <= RTP_PT_RESET;
            cfg_reg.stream_ssrc    <= STREAM_SSRC_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: accept a transaction whenever the job queue has room
    assign full   = job_full;
    assign accept = push && !job_full;

    hnrp_front #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_item (in_item),
        .cfg     (cfg_reg),
        .job     (job_in)
    );

    // Job queue decouples classification from byte serialization
    hnrp_fifo #(
        .WIDTH($bits(job_t)),
        .DEPTH(JOB_DEPTH)
    ) u_job_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_data (job_in),
        .full    (job_full),
        .rd_en   (job_pop),
        .rd_data (job_rd_bits),
        .empty   (job_empty)
    );

    assign job_head = job_t'(job_rd_bits);

    hnrp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job_head),
        .job_empty (job_empty),
        .job_pop   (job_pop),
        .cfg       (cfg_reg),
        .out_full  (out_full),
        .out_wr    (out_wr),
        .out_item  (byte_item)
    );

    // Output queue absorbs header bursts and parts the result side
    hnrp_fifo #(
        .WIDTH($bits(out_item_t)),
        .DEPTH(OUT_DEPTH)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (out_wr),
        .wr_data (byte_item),
        .full    (out_full),
        .rd_en   (pop),
        .rd_data (out_rd_bits),
        .empty   (empty)
    );

    assign out_item = out_item_t'(out_rd_bits);

endmodule

`default_nettype wire
